/* design/dae_pkg.sv */
package dae_pkg;

  // Event queue between parser and output stage
  localparam int DAE_QDEPTH = 4;
  localparam int DAE_QAW    = $clog2(DAE_QDEPTH);

  // Header and record field constants
  localparam int          DAE_HDR_LAST    = 11;
  localparam int          DAE_QFIXED_LAST = 3;
  localparam int          DAE_AFIXED_LAST = 9;
  localparam int          DAE_ADDR_LAST   = 3;
  localparam int          DAE_QR_BIT      = 15;
  localparam logic [15:0] DAE_RCODE_MASK  = 16'h000F;
  localparam logic [7:0]  DAE_PTR_MASK    = 8'hC0;
  localparam logic [15:0] DAE_TYPE_A      = 16'h0001;
  localparam logic [15:0] DAE_CLASS_IN    = 16'h0001;
  localparam logic [15:0] DAE_A_RDLEN     = 16'd4;

  // End-of-packet status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_RESP = 3'd2,
    ST_RCODE    = 3'd3,
    ST_TRUNC    = 3'd4
  } dae_status_t;

  // Result kinds
  typedef enum logic {
    KIND_ADDR   = 1'b0,
    KIND_STATUS = 1'b1
  } dae_kind_t;

  // Parser phases, one-hot
  typedef enum logic [11:0] {
    PH_HEADER = 12'b0000_0000_0001,
    PH_QNAME  = 12'b0000_0000_0010,
    PH_QLABEL = 12'b0000_0000_0100,
    PH_QPTR   = 12'b0000_0000_1000,
    PH_QFIXED = 12'b0000_0001_0000,
    PH_ANAME  = 12'b0000_0010_0000,
    PH_ALABEL = 12'b0000_0100_0000,
    PH_APTR   = 12'b0000_1000_0000,
    PH_AFIXED = 12'b0001_0000_0000,
    PH_AADDR  = 12'b0010_0000_0000,
    PH_ASKIP  = 12'b0100_0000_0000,
    PH_DONE   = 12'b1000_0000_0000
  } dae_phase_t;

  // One queued event: an address record, a status, or both
  typedef struct packed {
    logic        have_addr;
    logic [31:0] addr;
    logic [31:0] ttl;
    logic        have_status;
    dae_status_t status;
  } dae_evt_t;

  // Queue status seen by the top level and the output stage
  typedef struct packed {
    logic full;
    logic empty;
  } dae_qstat_t;

endpackage

/* design/dae_front.sv */
module dae_front
  import dae_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] packet_byte,
  input  logic       end_of_packet,
  output logic       evt_valid,
  output dae_evt_t   evt
);

  dae_phase_t  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] qleft_r, qleft_nxt;
  logic [15:0] aleft_r, aleft_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [15:0] rclass_r, rclass_nxt;
  logic [31:0] ttl_r, ttl_nxt;
  logic [15:0] rdlen_r, rdlen_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [31:0] acc_r, acc_nxt;
  dae_status_t lstat_r, lstat_nxt;

  dae_phase_t  p_phase;
  logic [3:0]  p_idx;
  dae_status_t p_lstat;
  logic        have_addr;
  dae_status_t status;

  // Per-byte parse step
  always_comb begin
    p_phase    = phase_r;
    p_idx      = idx_r;
    p_lstat    = lstat_r;
    qleft_nxt  = qleft_r;
    aleft_nxt  = aleft_r;
    flags_nxt  = flags_r;
    rtype_nxt  = rtype_r;
    rclass_nxt = rclass_r;
    ttl_nxt    = ttl_r;
    rdlen_nxt  = rdlen_r;
    skip_nxt   = skip_r;
    acc_nxt    = acc_r;
    have_addr  = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        case (idx_r)
          4'd2, 4'd3: flags_nxt = {flags_r[7:0], packet_byte};
          4'd4, 4'd5: qleft_nxt = {qleft_r[7:0], packet_byte};
          4'd6, 4'd7: aleft_nxt = {aleft_r[7:0], packet_byte};
          default: ;
        endcase
        if (idx_r >= 4'(DAE_HDR_LAST)) begin
          p_idx = '0;
          if (!flags_r[DAE_QR_BIT]) begin
            p_lstat = ST_NOT_RESP;
            p_phase = PH_DONE;
          end else if ((flags_r & DAE_RCODE_MASK) != '0) begin
            p_lstat = ST_RCODE;
            p_phase = PH_DONE;
          end else if (qleft_r != '0) begin
            p_phase = PH_QNAME;
          end else begin
            p_phase = (aleft_r != '0) ? PH_ANAME : PH_DONE;
          end
        end else begin
          p_idx = idx_r + 4'd1;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (packet_byte == '0) begin
          p_idx   = '0;
          p_phase = (phase_r == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
        end else if ((packet_byte & DAE_PTR_MASK) == DAE_PTR_MASK) begin
          p_phase = (phase_r == PH_QNAME) ? PH_QPTR : PH_APTR;
        end else begin
          skip_nxt = {8'd0, packet_byte};
          p_phase  = (phase_r == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
        end
      end
      PH_QLABEL, PH_ALABEL: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          p_phase = (phase_r == PH_QLABEL) ? PH_QNAME : PH_ANAME;
        end
      end
      PH_QPTR: begin
        p_idx   = '0;
        p_phase = PH_QFIXED;
      end
      PH_APTR: begin
        p_idx   = '0;
        p_phase = PH_AFIXED;
      end
      PH_QFIXED: begin
        if (idx_r >= 4'(DAE_QFIXED_LAST)) begin
          p_idx     = '0;
          qleft_nxt = qleft_r - 16'd1;
          if (qleft_nxt != '0) begin
            p_phase = PH_QNAME;
          end else begin
            p_phase = (aleft_r != '0) ? PH_ANAME : PH_DONE;
          end
        end else begin
          p_idx = idx_r + 4'd1;
        end
      end
      PH_AFIXED: begin
        // type, class, TTL, rdlength, all big-endian
        if (idx_r < 4'd2) begin
          rtype_nxt = {rtype_r[7:0], packet_byte};
        end else if (idx_r < 4'd4) begin
          rclass_nxt = {rclass_r[7:0], packet_byte};
        end else if (idx_r < 4'd8) begin
          ttl_nxt = {ttl_r[23:0], packet_byte};
        end else begin
          rdlen_nxt = {rdlen_r[7:0], packet_byte};
        end
        if (idx_r >= 4'(DAE_AFIXED_LAST)) begin
          p_idx = '0;
          if (rtype_r == DAE_TYPE_A && rclass_r == DAE_CLASS_IN &&
              rdlen_nxt == DAE_A_RDLEN) begin
            acc_nxt = '0;
            p_phase = PH_AADDR;
          end else if (rdlen_nxt == '0) begin
            aleft_nxt = aleft_r - 16'd1;
            p_phase   = (aleft_nxt != '0) ? PH_ANAME : PH_DONE;
          end else begin
            skip_nxt = rdlen_nxt;
            p_phase  = PH_ASKIP;
          end
        end else begin
          p_idx = idx_r + 4'd1;
        end
      end
      PH_AADDR: begin
        acc_nxt = {acc_r[23:0], packet_byte};
        if (idx_r >= 4'(DAE_ADDR_LAST)) begin
          p_idx     = '0;
          have_addr = 1'b1;
          aleft_nxt = aleft_r - 16'd1;
          p_phase   = (aleft_nxt != '0) ? PH_ANAME : PH_DONE;
        end else begin
          p_idx = idx_r + 4'd1;
        end
      end
      PH_ASKIP: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == '0) begin
          aleft_nxt = aleft_r - 16'd1;
          p_phase   = (aleft_nxt != '0) ? PH_ANAME : PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // End-of-packet status and return to header phase
  always_comb begin
    if (p_phase == PH_HEADER) begin
      status = ST_SHORT;
    end else if (p_lstat != ST_OK) begin
      status = p_lstat;
    end else if (p_phase != PH_DONE) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end

    if (end_of_packet) begin
      phase_nxt = PH_HEADER;
      idx_nxt   = '0;
      lstat_nxt = ST_OK;
    end else begin
      phase_nxt = p_phase;
      idx_nxt   = p_idx;
      lstat_nxt = p_lstat;
    end
  end

  // Event toward the queue
  always_comb begin
    evt_valid       = byte_valid && (have_addr || end_of_packet);
    evt.have_addr   = have_addr;
    evt.addr        = acc_nxt;
    evt.ttl         = ttl_r;
    evt.have_status = end_of_packet;
    evt.status      = status;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      lstat_r <= ST_OK;
    end else if (byte_valid) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      lstat_r <= lstat_nxt;
    end
  end

  // Field registers, always overwritten before use
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      qleft_r  <= qleft_nxt;
      aleft_r  <= aleft_nxt;
      flags_r  <= flags_nxt;
      rtype_r  <= rtype_nxt;
      rclass_r <= rclass_nxt;
      ttl_r    <= ttl_nxt;
      rdlen_r  <= rdlen_nxt;
      skip_r   <= skip_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

/* design/dae_queue.sv */
module dae_queue
  import dae_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  dae_evt_t   wr_data,
  input  logic       rd_en,
  output dae_evt_t   rd_data,
  output dae_qstat_t stat
);

  dae_evt_t           mem [DAE_QDEPTH];
  logic [DAE_QAW-1:0] wptr_r, wptr_nxt;
  logic [DAE_QAW-1:0] rptr_r, rptr_nxt;
  logic [DAE_QAW:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign stat.full  = (cnt_r == (DAE_QAW+1)'(DAE_QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

endmodule

/* design/dae_back.sv */
module dae_back
  import dae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dae_evt_t    q_data,
  input  dae_qstat_t  q_stat,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic        result_kind,
  output logic [31:0] ipv4_address,
  output logic [31:0] time_to_live,
  output logic [2:0]  packet_status,
  output logic        last_of_run
);

  dae_evt_t cur_r;
  logic     valid_r, valid_nxt;
  logic     addr_sent_r, addr_sent_nxt;
  logic     show_addr;
  logic     word_done;
  logic     load;

  // Address word goes first when an event carries both
  assign show_addr = cur_r.have_addr && !addr_sent_r;
  assign word_done = valid_r && pop;
  assign load      = !valid_r || (word_done && !(show_addr && cur_r.have_status));
  assign q_pop     = load && !q_stat.empty;

  always_comb begin
    valid_nxt     = valid_r;
    addr_sent_nxt = addr_sent_r;
    if (load) begin
      valid_nxt     = !q_stat.empty;
      addr_sent_nxt = 1'b0;
    end else if (word_done) begin
      addr_sent_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      addr_sent_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      addr_sent_r <= addr_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // Result word fields
  always_comb begin
    empty = !valid_r;
    if (show_addr) begin
      result_kind   = KIND_ADDR;
      ipv4_address  = cur_r.addr;
      time_to_live  = cur_r.ttl;
      packet_status = ST_OK;
      last_of_run   = !cur_r.have_status;
    end else begin
      result_kind   = KIND_STATUS;
      ipv4_address  = '0;
      time_to_live  = '0;
      packet_status = cur_r.status;
      last_of_run   = 1'b1;
    end
  end

endmodule

/* design/dns_a_record_extractor.sv */
// DNS A-record extractor. Reply bytes enter at one per clock on the in_ queue
// interface, in_end_of_packet marking the last byte. The parser checks the
// header, skips questions, and for each IN A answer with rdlength 4 emits an
// address word (address and TTL); at the end mark it emits a status word
// (ok, short header, not a response, error rcode, truncated) and rearms for
// the next reply. A byte is taken every cycle while in_full is low; results
// pass through a 4-entry event queue to an output stage that delivers one
// word per cycle while out_pop is high, so a byte that yields both an address
// and a status gives two output words. in_full rises only when that queue
// fills because out_pop is held low or such double words pile up. A record's
// word passes through the queue and the output register to the out_ ports.
module dns_a_record_extractor
  import dae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_result_kind,
  output logic [31:0] out_ipv4_address,
  output logic [31:0] out_time_to_live,
  output logic [2:0]  out_packet_status,
  output logic        out_last_of_run
);

  logic       byte_valid;
  logic       evt_valid;
  dae_evt_t   evt;
  dae_evt_t   q_data;
  dae_qstat_t q_stat;
  logic       q_pop;

  assign in_full    = q_stat.full;
  assign byte_valid = in_push && !q_stat.full;

  dae_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (byte_valid),
    .packet_byte   (in_packet_byte),
    .end_of_packet (in_end_of_packet),
    .evt_valid     (evt_valid),
    .evt           (evt)
  );

  dae_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (evt_valid),
    .wr_data (evt),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  dae_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_data        (q_data),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .pop           (out_pop),
    .empty         (out_empty),
    .result_kind   (out_result_kind),
    .ipv4_address  (out_ipv4_address),
    .time_to_live  (out_time_to_live),
    .packet_status (out_packet_status),
    .last_of_run   (out_last_of_run)
  );

endmodule

/* bench/dns_a_record_extractor_tb.sv */
`timescale 1ns / 1ps

module dns_a_record_extractor_tb;
  import dae_pkg::*;

  // One result word as seen on the out_ ports
  typedef struct packed {
    dae_kind_t   kind;
    logic [31:0] addr;
    logic [31:0] ttl;
    dae_status_t status;
    logic        last;
  } dns_word_t;

  // Directed stimulus row; typed rows carry the status read off by hand
  typedef struct packed {
    logic [7:0]  b;
    logic        eop;
    logic        typed;
    dae_status_t st;
  } dir_row_t;

  localparam int RANDOM_BYTES = 1950;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AFTER  = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_packet_byte;
  logic        in_end_of_packet;
  logic        out_empty;
  logic        out_pop;
  logic        out_result_kind;
  logic [31:0] out_ipv4_address;
  logic [31:0] out_time_to_live;
  logic [2:0]  out_packet_status;
  logic        out_last_of_run;

  dns_a_record_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_packet_byte    (in_packet_byte),
    .in_end_of_packet  (in_end_of_packet),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_result_kind   (out_result_kind),
    .out_ipv4_address  (out_ipv4_address),
    .out_time_to_live  (out_time_to_live),
    .out_packet_status (out_packet_status),
    .out_last_of_run   (out_last_of_run)
  );

  // Parser shadow state
  dae_phase_t  parse_ph;
  logic [3:0]  byte_idx;
  logic [15:0] q_left;
  logic [15:0] a_left;
  logic [15:0] hdr_flags;
  logic [15:0] rec_type;
  logic [15:0] rec_class;
  logic [31:0] rec_ttl;
  logic [15:0] rec_len;
  logic [15:0] skip_left;
  logic [31:0] addr_acc;
  dae_status_t held_status;

  dns_word_t   pending_words[$];
  logic [7:0]  reply_q[$];
  int          errors;
  int          items_done;
  int          idle_mode;
  bit          stall_active;
  bit          held_once;

  // Directed part: short reply, QR clear, then an empty but valid reply
  dir_row_t dir_rows [25] = '{
    '{8'h00, 1'b1, 1'b1, ST_SHORT},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h7F, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_NOT_RESP},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b1, 1'b1, ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dns_a_record_extractor_tb failed");
    $finish;
  end

  task automatic clear_parser();
    parse_ph    = PH_HEADER;
    byte_idx    = '0;
    q_left      = '0;
    a_left      = '0;
    hdr_flags   = '0;
    rec_type    = '0;
    rec_class   = '0;
    rec_ttl     = '0;
    rec_len     = '0;
    skip_left   = '0;
    addr_acc    = '0;
    held_status = ST_OK;
  endtask

  // Append one expected word at the tail
  task automatic add_word(input dns_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // Append one byte to the reply under construction
  task automatic add_byte(input logic [7:0] b);
    reply_q.insert(reply_q.size(), b);
  endtask

  task automatic close_answer();
    a_left = a_left - 16'd1;
    if (a_left != 0) parse_ph = PH_ANAME;
    else parse_ph = PH_DONE;
  endtask

  // Advance the shadow parser by one byte and queue the words it yields
  task automatic parse_byte(input logic [7:0] b, input logic eop);
    logic        got_addr;
    logic [31:0] addr_out;
    logic [31:0] ttl_out;
    logic        in_q;
    dns_word_t   w;
    got_addr = 1'b0;
    addr_out = '0;
    ttl_out  = '0;
    in_q     = (parse_ph == PH_QNAME) || (parse_ph == PH_QLABEL);
    case (parse_ph)
      PH_HEADER: begin
        case (byte_idx)
          4'd2, 4'd3: hdr_flags = {hdr_flags[7:0], b};
          4'd4, 4'd5: q_left    = {q_left[7:0], b};
          4'd6, 4'd7: a_left    = {a_left[7:0], b};
          default: ;
        endcase
        if (byte_idx >= DAE_HDR_LAST) begin
          byte_idx = '0;
          if (!hdr_flags[DAE_QR_BIT]) begin
            held_status = ST_NOT_RESP;
            parse_ph    = PH_DONE;
          end else if ((hdr_flags & DAE_RCODE_MASK) != 0) begin
            held_status = ST_RCODE;
            parse_ph    = PH_DONE;
          end else if (q_left != 0) begin
            parse_ph = PH_QNAME;
          end else if (a_left != 0) begin
            parse_ph = PH_ANAME;
          end else begin
            parse_ph = PH_DONE;
          end
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      // Name position: end, compression pointer or label length
      PH_QNAME, PH_ANAME: begin
        if (b == 8'h00) begin
          byte_idx = '0;
          if (in_q) parse_ph = PH_QFIXED;
          else parse_ph = PH_AFIXED;
        end else if ((b & DAE_PTR_MASK) == DAE_PTR_MASK) begin
          if (in_q) parse_ph = PH_QPTR;
          else parse_ph = PH_APTR;
        end else begin
          skip_left = {8'h00, b};
          if (in_q) parse_ph = PH_QLABEL;
          else parse_ph = PH_ALABEL;
        end
      end
      PH_QLABEL, PH_ALABEL: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) begin
          if (in_q) parse_ph = PH_QNAME;
          else parse_ph = PH_ANAME;
        end
      end
      PH_QPTR: begin
        byte_idx = '0;
        parse_ph = PH_QFIXED;
      end
      PH_APTR: begin
        byte_idx = '0;
        parse_ph = PH_AFIXED;
      end
      PH_QFIXED: begin
        if (byte_idx >= DAE_QFIXED_LAST) begin
          byte_idx = '0;
          q_left   = q_left - 16'd1;
          if (q_left != 0) parse_ph = PH_QNAME;
          else if (a_left != 0) parse_ph = PH_ANAME;
          else parse_ph = PH_DONE;
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      // type, class, TTL, rdlength, all big-endian
      PH_AFIXED: begin
        if (byte_idx < 2) rec_type = {rec_type[7:0], b};
        else if (byte_idx < 4) rec_class = {rec_class[7:0], b};
        else if (byte_idx < 8) rec_ttl = {rec_ttl[23:0], b};
        else rec_len = {rec_len[7:0], b};
        if (byte_idx >= DAE_AFIXED_LAST) begin
          byte_idx = '0;
          if (rec_type == DAE_TYPE_A && rec_class == DAE_CLASS_IN &&
              rec_len == DAE_A_RDLEN) begin
            addr_acc = '0;
            parse_ph = PH_AADDR;
          end else if (rec_len == 0) begin
            close_answer();
          end else begin
            skip_left = rec_len;
            parse_ph  = PH_ASKIP;
          end
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      PH_AADDR: begin
        addr_acc = {addr_acc[23:0], b};
        if (byte_idx >= DAE_ADDR_LAST) begin
          byte_idx = '0;
          got_addr = 1'b1;
          addr_out = addr_acc;
          ttl_out  = rec_ttl;
          close_answer();
        end else begin
          byte_idx = byte_idx + 4'd1;
        end
      end
      PH_ASKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) close_answer();
      end
      default: ;
    endcase

    if (got_addr) begin
      w.kind   = KIND_ADDR;
      w.addr   = addr_out;
      w.ttl    = ttl_out;
      w.status = ST_OK;
      w.last   = !eop;
      add_word(w);
    end
    // End mark: status word, then rearm for the next reply
    if (eop) begin
      w.kind = KIND_STATUS;
      w.addr = '0;
      w.ttl  = '0;
      w.last = 1'b1;
      if (parse_ph == PH_HEADER) w.status = ST_SHORT;
      else if (held_status != ST_OK) w.status = held_status;
      else if (parse_ph != PH_DONE) w.status = ST_TRUNC;
      else w.status = ST_OK;
      add_word(w);
      clear_parser();
    end
  endtask

  // Offer one byte after an optional gap; returns once it is taken
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int gap;
    gap = 0;
    if (!stall_active && idle_mode != 0)
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_packet_byte   <= b;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte(b, eop);
    items_done++;
  endtask

  task automatic add_name();
    int nl;
    int len;
    nl = $urandom_range(0, 3);
    repeat (nl) begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 6);
      add_byte(len[7:0]);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte(DAE_PTR_MASK | 8'($urandom_range(0, 63)));
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_byte(8'h00);
    end
  endtask

  // Build one reply: mostly well-formed, some cut short, some pure noise
  task automatic build_reply();
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rdlen;
    logic [31:0] ttl_v;
    logic [3:0]  rcode;
    logic        qr;
    int          cut;
    reply_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    qr    = ($urandom_range(0, 19) != 0);
    rcode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    qd    = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    an    = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_byte({qr, 7'($urandom_range(0, 127))});
    add_byte({4'($urandom_range(0, 15)), rcode});
    add_byte(qd[15:8]);
    add_byte(qd[7:0]);
    add_byte(an[15:8]);
    add_byte(an[7:0]);
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    repeat ((qd > 4) ? 4 : qd) begin
      add_name();
      repeat (4) add_byte(8'($urandom_range(0, 255)));
    end
    repeat ((an > 5) ? 5 : an) begin
      add_name();
      rtype  = ($urandom_range(0, 9) != 0) ? DAE_TYPE_A : 16'($urandom);
      rclass = ($urandom_range(0, 9) != 0) ? DAE_CLASS_IN : 16'($urandom);
      rdlen  = ($urandom_range(0, 4) != 0) ? DAE_A_RDLEN : 16'($urandom_range(0, 8));
      ttl_v  = $urandom;
      add_byte(rtype[15:8]);
      add_byte(rtype[7:0]);
      add_byte(rclass[15:8]);
      add_byte(rclass[7:0]);
      for (int i = 3; i >= 0; i--) add_byte(ttl_v[i*8 +: 8]);
      add_byte(rdlen[15:8]);
      add_byte(rdlen[7:0]);
      repeat (rdlen) add_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, reply_q.size());
      while (reply_q.size() > cut) void'(reply_q.pop_back());
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sender: reset, directed rows, random replies, drain
  initial begin
    dns_word_t w;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_packet_byte   = '0;
    in_end_of_packet = 1'b0;
    errors           = 0;
    items_done       = 0;
    idle_mode        = 0;
    stall_active     = 1'b0;
    held_once        = 1'b0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].eop);
      if (dir_rows[i].typed) begin
        w        = pending_words.pop_back();
        w.status = dir_rows[i].st;
        add_word(w);
      end
    end

    items_done = 0;
    while (items_done < RANDOM_BYTES) begin
      idle_mode = $urandom_range(0, 3);
      build_reply();
      foreach (reply_q[i]) send_byte(reply_q[i], i == reply_q.size() - 1);
      // once mid-run, hold off until every word has come out
      if (items_done >= DRAIN_AFTER && !held_once) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
        held_once = 1'b1;
      end
    end
    in_push <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!out_empty) begin
      $display("%0t: out_empty mismatch: expected 1, got %0d", $time, out_empty);
      errors++;
    end
    if (errors == 0) $display("dns_a_record_extractor_tb passed");
    else $display("dns_a_record_extractor_tb failed");
    $finish;
  end

  // Receiver: checks each popped word, pops with random stalls
  initial begin
    dns_word_t w;
    int        hold_left;
    int        rx_mode;
    int        rx_left;
    bit        long_done;
    out_pop   = 1'b0;
    hold_left = 0;
    rx_mode   = 0;
    rx_left   = 0;
    long_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word: kind %0d addr %h ttl %h status %0d", $time,
                   out_result_kind, out_ipv4_address, out_time_to_live, out_packet_status);
          errors++;
        end else begin
          w = pending_words.pop_front();
          report_field("result_kind", 32'(w.kind), 32'(out_result_kind));
          report_field("ipv4_address", w.addr, out_ipv4_address);
          report_field("time_to_live", w.ttl, out_time_to_live);
          report_field("packet_status", 32'(w.status), 32'(out_packet_status));
          report_field("last_of_run", 32'(w.last), 32'(out_last_of_run));
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) stall_active = 1'b0;
        out_pop <= 1'b0;
      end else if (!long_done && items_done >= HOLD_AFTER) begin
        // long back-pressure stretch so the event queue fills
        long_done    = 1'b1;
        stall_active = 1'b1;
        hold_left    = HOLD_CYCLES;
        out_pop <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        if (rx_mode != 0 && $urandom_range(0, 60) == 0) begin
          hold_left = $urandom_range(10, 40);
          out_pop <= 1'b0;
        end else if (rx_mode == 0) begin
          out_pop <= 1'b1;
        end else if (rx_mode == 1) begin
          out_pop <= $urandom_range(0, 1);
        end else begin
          out_pop <= ($urandom_range(0, 7) != 0);
        end
      end
    end
  end

endmodule

/* files.f */
design/dae_pkg.sv
design/dae_front.sv
design/dae_queue.sv
design/dae_back.sv
design/dns_a_record_extractor.sv
bench/dns_a_record_extractor_tb.sv
